// File: rtl/arpc_pkg.sv
// Shared types, codes and widths for the alphabet remap / prefix count block.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package arpc_pkg;

  // Sizes
  localparam int COUNT_BITS  = 32;
  localparam int SYM_BITS    = 8;
  localparam int NUM_SYM     = 256;
  localparam int PREFIX_BITS = 32;
  localparam int STEP_BITS   = SYM_BITS + 1;
  localparam int SUM_BITS    = ((COUNT_BITS > PREFIX_BITS) ? COUNT_BITS : PREFIX_BITS) + 1;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = 2 + 3 * SYM_BITS + PREFIX_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Action codes (in_tuser)
  typedef logic [1:0] action_t;
  localparam action_t ACT_COUNT = 2'd0;
  localparam action_t ACT_FINAL = 2'd1;
  localparam action_t ACT_READ  = 2'd2;
  localparam action_t ACT_CLEAR = 2'd3;

  // Status codes
  typedef logic [1:0] status_code_t;
  localparam status_code_t ST_OK   = 2'd0;
  localparam status_code_t ST_OVF  = 2'd1;
  localparam status_code_t ST_TERM = 2'd2;
  localparam status_code_t ST_SAT  = 2'd3;

  // Sticky flag bit positions
  typedef logic [2:0] flags_t;
  localparam int FLAG_OVF  = 0;
  localparam int FLAG_TERM = 1;
  localparam int FLAG_SAT  = 2;

  // Fixed codes and limits
  localparam logic [SYM_BITS-1:0]    CODE_TERM  = 8'd1;
  localparam logic [STEP_BITS-1:0]   FIRST_CODE = 9'd2;
  localparam logic [SYM_BITS-1:0]    DIST_MAX   = 8'd255;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
  localparam logic [PREFIX_BITS-1:0] PREFIX_MAX = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // capture item, issue reads
    logic exec;        // run count / read / clear, load result
    logic scan_start;  // arm finalize scan
    logic scan_step;   // advance the finalize scan
    logic fill_step;   // advance the fill
    logic final_done;  // tables valid, load result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_final;
    logic out_free;
    logic scan_last;
    logic fill_last;
  } dp_stat_t;

  // Priority: overflow, then saturation, then terminator
  function automatic status_code_t status_of(flags_t f);
    status_code_t s;
    if (f[FLAG_OVF])       s = ST_OVF;
    else if (f[FLAG_SAT])  s = ST_SAT;
    else if (f[FLAG_TERM]) s = ST_TERM;
    else                   s = ST_OK;
    return s;
  endfunction

endpackage

// File: rtl/arpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/arpc_ctrl.sv
// Controller state machine: sequences item execution and the finalize scan/fill.
// Depends on arpc_pkg.
module arpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  arpc_pkg::dp_stat_t   stat,
  output arpc_pkg::ctrl_cmd_t  cmd
);
  import arpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FILL = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          if (stat.is_final) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.exec  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.final_done = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// File: rtl/arpc_dpath.sv
// Datapath: histogram memory, the three lookup tables, sticky flags and the
// output register. Depends on arpc_pkg and arpc_ram.
module arpc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  arpc_pkg::ctrl_cmd_t                cmd,
  output arpc_pkg::dp_stat_t                 stat,
  input  logic [arpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [arpc_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [arpc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import arpc_pkg::*;

  // Captured item
  action_t             act_r;
  logic [SYM_BITS-1:0] sym_r;

  // Finalize walk
  logic [STEP_BITS-1:0]   step_r;
  logic [STEP_BITS-1:0]   next_r;
  logic [PREFIX_BITS-1:0] sum_r;

  // Control and sticky state
  logic [NUM_SYM-1:0]  cnt_vld_r;
  logic                cnt_rvld_r;
  logic                tbl_vld_r;
  logic [SYM_BITS-1:0] dist_r;
  logic [SYM_BITS-1:0] dist_nxt;
  flags_t              flags_r;
  flags_t              flags_nxt;

  // Output register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Memory ports
  logic                   cnt_re;
  logic [SYM_BITS-1:0]    cnt_raddr;
  logic [COUNT_BITS-1:0]  cnt_raw;
  logic                   cnt_we;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic                   code_we;
  logic [SYM_BITS-1:0]    code_wa;
  logic [SYM_BITS-1:0]    code_wd;
  logic [SYM_BITS-1:0]    code_raw;
  logic                   inv_we;
  logic [SYM_BITS-1:0]    inv_wa;
  logic [SYM_BITS-1:0]    inv_wd;
  logic [SYM_BITS-1:0]    inv_raw;
  logic                   pre_we;
  logic [SYM_BITS-1:0]    pre_wa;
  logic [PREFIX_BITS-1:0] pre_wd;
  logic [PREFIX_BITS-1:0] pre_raw;

  // Scan helpers
  logic                   scan_proc;
  logic [SYM_BITS-1:0]    scan_byte;
  logic                   scan_b0;
  logic                   gets_code;
  logic                   adds_pre;
  logic [SUM_BITS-1:0]    sum_ext;
  logic                   sum_ovf;
  logic [PREFIX_BITS-1:0] sum_new;

  // Read results
  logic [SYM_BITS-1:0]    code_rd;
  logic [SYM_BITS-1:0]    inv_rd;
  logic [PREFIX_BITS-1:0] pre_rd;
  logic                   load;

  // Histogram read port: item symbol at accept, walk index while scanning
  assign cnt_re    = cmd.accept | (cmd.scan_step & ~step_r[SYM_BITS]);
  assign cnt_raddr = cmd.accept ? in_tdata[SYM_BITS-1:0] : step_r[SYM_BITS-1:0];
  assign cnt_q     = cnt_rvld_r ? cnt_raw : '0;
  assign cnt_inc   = cnt_q + COUNT_BITS'(1);

  arpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SYM)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (sym_r),
    .wdata (cnt_inc),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_raw)
  );

  arpc_ram #(.WIDTH(SYM_BITS), .DEPTH(NUM_SYM)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (code_wa),
    .wdata (code_wd),
    .re    (cmd.accept),
    .raddr (in_tdata[SYM_BITS-1:0]),
    .rdata (code_raw)
  );

  arpc_ram #(.WIDTH(SYM_BITS), .DEPTH(NUM_SYM)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_wa),
    .wdata (inv_wd),
    .re    (cmd.accept),
    .raddr (in_tdata[SYM_BITS-1:0]),
    .rdata (inv_raw)
  );

  arpc_ram #(.WIDTH(PREFIX_BITS), .DEPTH(NUM_SYM)) u_pre_ram (
    .clk   (clk),
    .we    (pre_we),
    .waddr (pre_wa),
    .wdata (pre_wd),
    .re    (cmd.accept),
    .raddr (in_tdata[SYM_BITS-1:0]),
    .rdata (pre_raw)
  );

  // Scan: data of byte step-1 arrives while step is read
  assign scan_proc = cmd.scan_step & (step_r != '0);
  assign scan_byte = step_r[SYM_BITS-1:0] - SYM_BITS'(1);
  assign scan_b0   = (scan_byte == '0);
  assign gets_code = (cnt_q != '0) && (next_r <= STEP_BITS'(NUM_SYM - 1));
  assign adds_pre  = (next_r <= STEP_BITS'(NUM_SYM - 2));

  // Saturating running sum of code frequencies
  assign sum_ext = SUM_BITS'(sum_r) + SUM_BITS'(cnt_q);
  assign sum_ovf = (sum_ext > SUM_BITS'(PREFIX_MAX));
  assign sum_new = sum_ovf ? PREFIX_MAX : sum_ext[PREFIX_BITS-1:0];

  // Table write ports for scan and fill
  always_comb begin
    code_we = 1'b0;
    code_wa = scan_byte;
    code_wd = '0;
    inv_we  = 1'b0;
    inv_wa  = next_r[SYM_BITS-1:0];
    inv_wd  = scan_byte;
    pre_we  = 1'b0;
    pre_wa  = next_r[SYM_BITS-1:0] + SYM_BITS'(1);
    pre_wd  = sum_new;
    if (scan_proc) begin
      code_we = 1'b1;
      if (scan_b0) begin
        code_wd = CODE_TERM;
        pre_we  = 1'b1;
        pre_wa  = FIRST_CODE[SYM_BITS-1:0];
      end else if (gets_code) begin
        code_wd = next_r[SYM_BITS-1:0];
        inv_we  = 1'b1;
        pre_we  = adds_pre;
      end
    end else if (cmd.fill_step) begin
      // zero unused inverse entries, pad prefix tail with the final sum
      inv_wa = step_r[SYM_BITS-1:0];
      inv_wd = '0;
      inv_we = (step_r < FIRST_CODE) || (step_r >= next_r);
      pre_wa = step_r[SYM_BITS-1:0];
      pre_wd = (step_r < FIRST_CODE) ? '0 : sum_r;
      pre_we = (step_r < FIRST_CODE) || (step_r > next_r);
    end
  end

  // Flags, distinct count and histogram update
  always_comb begin
    flags_nxt = flags_r;
    dist_nxt  = dist_r;
    cnt_we    = 1'b0;
    if (cmd.exec) begin
      unique case (act_r)
        ACT_COUNT: begin
          if ((cnt_q == '0) && (dist_r != DIST_MAX)) begin
            dist_nxt = dist_r + SYM_BITS'(1);
          end
          if (cnt_q == COUNT_MAX) begin
            flags_nxt[FLAG_SAT] = 1'b1;
          end else begin
            cnt_we = 1'b1;
          end
          if (dist_nxt == DIST_MAX) begin
            flags_nxt[FLAG_OVF] = 1'b1;
          end
        end
        ACT_CLEAR: begin
          flags_nxt = '0;
          dist_nxt  = '0;
        end
        default: ;
      endcase
    end
    if (scan_proc) begin
      if (scan_b0) begin
        flags_nxt[FLAG_TERM] = (cnt_q != COUNT_BITS'(1));
        if (sum_ovf) flags_nxt[FLAG_SAT] = 1'b1;
      end else if (gets_code && adds_pre && sum_ovf) begin
        flags_nxt[FLAG_SAT] = 1'b1;
      end
    end
  end

  // Read results, reset tables until a finalize and again after a clear
  assign code_rd = tbl_vld_r ? code_raw : ((sym_r == '0) ? CODE_TERM : '0);
  assign inv_rd  = tbl_vld_r ? inv_raw : '0;
  assign pre_rd  = tbl_vld_r ? pre_raw : '0;
  assign load    = cmd.exec | cmd.final_done;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= action_t'(in_tuser);
      sym_r <= in_tdata[SYM_BITS-1:0];
    end
  end

  // Finalize walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      next_r <= FIRST_CODE;
      sum_r  <= '0;
    end else if (cmd.scan_start) begin
      step_r <= '0;
      next_r <= FIRST_CODE;
      sum_r  <= '0;
    end else if (cmd.scan_step) begin
      step_r <= stat.scan_last ? '0 : step_r + STEP_BITS'(1);
      if (scan_proc) begin
        if (scan_b0) begin
          sum_r <= sum_new;
        end else if (gets_code) begin
          next_r <= next_r + STEP_BITS'(1);
          if (adds_pre) sum_r <= sum_new;
        end
      end
    end else if (cmd.fill_step) begin
      step_r <= step_r + STEP_BITS'(1);
    end
  end

  // Sticky state and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      cnt_rvld_r <= 1'b0;
      tbl_vld_r  <= 1'b0;
      dist_r     <= '0;
      flags_r    <= '0;
    end else begin
      dist_r  <= dist_nxt;
      flags_r <= flags_nxt;
      if (cnt_re) cnt_rvld_r <= cnt_vld_r[cnt_raddr];
      if (cmd.exec && (act_r == ACT_CLEAR)) begin
        cnt_vld_r <= '0;
        tbl_vld_r <= 1'b0;
      end else begin
        if (cnt_we) cnt_vld_r[sym_r] <= 1'b1;
        if (cmd.final_done) tbl_vld_r <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.exec && (act_r == ACT_READ)) begin
        out_data_r <= {{OUT_PAD_W{1'b0}}, pre_rd, inv_rd, code_rd, dist_nxt,
                       status_of(flags_nxt)};
      end else begin
        out_data_r <= {{OUT_PAD_W{1'b0}}, {PREFIX_BITS{1'b0}}, {SYM_BITS{1'b0}},
                       {SYM_BITS{1'b0}}, dist_nxt, status_of(flags_nxt)};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Status to controller
  assign stat.is_final  = (act_r == ACT_FINAL);
  assign stat.out_free  = ~out_vld_r | out_tready;
  assign stat.scan_last = (step_r == STEP_BITS'(NUM_SYM));
  assign stat.fill_last = (step_r == STEP_BITS'(NUM_SYM - 1));

endmodule

// File: rtl/alphabet_remap_prefix_counts_top.sv
// Top level of the alphabet remap / prefix count block.
// Depends on arpc_pkg, arpc_ctrl, arpc_dpath and arpc_ram.

// Each item carries an action in in_tuser and a byte in in_tdata and yields
// exactly one result item. Count, read and clear load their result in the
// execute state once the output register is free, and a new item is only
// accepted after the previous one has executed, as the histogram memory does
// a read-modify-write of one count. Finalize walks the histogram once (one
// memory read per cycle), then fills the unused table entries and loads its
// result when the fill ends. The input side takes the next item while a
// result still waits in the output register. Reads before the first finalize
// return the reset tables; counting after a finalize leaves them unchanged.
module alphabet_remap_prefix_counts_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [arpc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] symbol
  input  logic [arpc_pkg::IN_TUSER_W-1:0]   in_tuser,   // [1:0] action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [9:2] distinct_symbols, [17:10] code_of_byte,
  // [25:18] byte_of_code, [57:26] prefix_count, [63:58] zero
  output logic [arpc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import arpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables, histogram and result register
  arpc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/arpc_checker.sv
// Port-level checker for the alphabet remap / prefix count block, bound to
// the top level. Depends on arpc_pkg.
module arpc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [arpc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import arpc_pkg::*;

  // One item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while previous item still executing");

  // A new result is shown only once the block is free for the next item
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result loaded while item still in progress");

  // A full alphabet always reports overflow
  a_full_alphabet_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:2] == DIST_MAX)) |-> (out_tdata[1:0] == ST_OVF))
    else $error("255 distinct symbols without overflow status");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind alphabet_remap_prefix_counts_top arpc_checker u_arpc_checker (.*);
